@@ rtl/core/es2c_pkg.sv @@
package es2c_pkg;

    localparam int SecWidth    = 32;
    localparam int OffsetWidth = 17;
    localparam int TimeWidth   = SecWidth + 1;
    localparam int DaysWidth   = 16;
    localparam int DivWidth    = 17;

    localparam logic signed [OffsetWidth-1:0] OFFSET_RESET = 17'sd10800;

    localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
    localparam logic [1:0]  EPOCH_MOD4      = 2'd2;
    localparam logic [6:0]  EPOCH_MOD100    = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400    = 9'd370;
    localparam logic [3:0]  LAST_MONTH      = 4'd11;

    // reciprocals of the odd parts of the divisors: 86400 = 128 * 675,
    // 3600 = 16 * 225, 60 = 4 * 15; the power-of-two part is shifted out first
    localparam logic [26:0] DAY_RECIP  = 27'd101806633;  // ceil(2^36 / 675)
    localparam logic [13:0] HOUR_RECIP = 14'd9321;       // ceil(2^21 / 225)
    localparam logic [10:0] MIN_RECIP  = 11'd1093;       // ceil(2^14 / 15)

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_DAY,
        ST_DIV_HOUR,
        ST_DIV_MIN,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_DAY_SEL,
        DIV_HOUR_SEL,
        DIV_MIN_SEL
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_quo;
        logic     div_rem;
        div_sel_t div_sel;
        logic     save_days;
        logic     save_hour;
        logic     save_min;
        logic     year_step;
        logic     month_step;
    } cmd_t;

    typedef struct packed {
        logic year_fits;
        logic month_done;
    } status_t;

    function automatic logic [DivWidth-1:0] div_const(input div_sel_t sel);
        logic [DivWidth-1:0] d;
        case (sel)
            DIV_DAY_SEL:  d = 17'd86400;
            DIV_HOUR_SEL: d = 17'd3600;
            DIV_MIN_SEL:  d = 17'd60;
            default:      d = 17'd60;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/core/es2c_ctrl.sv @@
module es2c_ctrl
    import es2c_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // each division: quotient step (phase low), then remainder step (phase high)
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cmd         = '0;
        cmd.div_sel = DIV_DAY_SEL;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_DIV_DAY;
                end
            end
            ST_DIV_DAY:
            begin
                cmd.div_sel = DIV_DAY_SEL;
                if (!phase_reg)
                begin
                    cmd.div_quo = 1'b1;
                    phase_next  = 1'b1;
                end
                else
                begin
                    cmd.div_rem   = 1'b1;
                    cmd.save_days = 1'b1;
                    phase_next    = 1'b0;
                    state_next    = ST_DIV_HOUR;
                end
            end
            ST_DIV_HOUR:
            begin
                cmd.div_sel = DIV_HOUR_SEL;
                if (!phase_reg)
                begin
                    cmd.div_quo = 1'b1;
                    phase_next  = 1'b1;
                end
                else
                begin
                    cmd.div_rem   = 1'b1;
                    cmd.save_hour = 1'b1;
                    phase_next    = 1'b0;
                    state_next    = ST_DIV_MIN;
                end
            end
            ST_DIV_MIN:
            begin
                cmd.div_sel = DIV_MIN_SEL;
                if (!phase_reg)
                begin
                    cmd.div_quo = 1'b1;
                    phase_next  = 1'b1;
                end
                else
                begin
                    cmd.div_rem  = 1'b1;
                    cmd.save_min = 1'b1;
                    phase_next   = 1'b0;
                    state_next   = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                cmd.year_step = 1'b1;
                if (status.year_fits)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                cmd.month_step = 1'b1;
                if (status.month_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not start work");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!busy && start))
        else $error("load outside of accept");

endmodule

@@ rtl/core/es2c_datapath.sv @@
module es2c_datapath
    import es2c_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   utc_offset_we,
    input  logic [OffsetWidth-1:0] utc_offset_seconds,
    input  logic [SecWidth-1:0]    seconds_since_epoch,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic [11:0]            year,
    output logic [3:0]             month,
    output logic [4:0]             day,
    output logic [4:0]             hour,
    output logic [5:0]             minute,
    output logic [5:0]             second
);

    logic [OffsetWidth-1:0] offset_reg;
    logic [TimeWidth-1:0]   rem_reg, rem_next;
    logic [DaysWidth-1:0]   quo_reg, quo_next;
    logic [DaysWidth-1:0]   days_reg, days_next;
    logic [4:0]             hour_reg;
    logic [5:0]             minute_reg;
    logic [11:0]            year_reg, year_next;
    logic [1:0]             mod4_reg, mod4_next;
    logic [6:0]             mod100_reg, mod100_next;
    logic [8:0]             mod400_reg, mod400_next;
    logic [3:0]             month_reg, month_next;

    logic [TimeWidth:0]     sum;
    logic [52:0]            day_prod;
    logic [26:0]            hour_prod;
    logic [20:0]            min_prod;
    logic [DaysWidth-1:0]   quo_calc;
    logic [TimeWidth-1:0]   quo_times_d;
    logic                   leap;
    logic [8:0]             year_len;
    logic [4:0]             mon_len;
    logic                   year_fits;
    logic                   month_fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (utc_offset_we)
        begin
            offset_reg <= utc_offset_seconds;
        end
    end

    // signed 34-bit sum, negative saturates to zero
    assign sum = {2'b00, seconds_since_epoch}
               + {{(TimeWidth + 1 - OffsetWidth){offset_reg[OffsetWidth-1]}}, offset_reg};

    // quotients by reciprocal multiplication, exact over each dividend's range
    assign day_prod  = {27'd0, rem_reg[TimeWidth-1:7]} * {26'd0, DAY_RECIP};
    assign hour_prod = {14'd0, rem_reg[16:4]} * {13'd0, HOUR_RECIP};
    assign min_prod  = {11'd0, rem_reg[11:2]} * {10'd0, MIN_RECIP};

    always_comb
    begin
        case (cmd.div_sel)
            DIV_DAY_SEL:  quo_calc = day_prod[DaysWidth+35:36];
            DIV_HOUR_SEL: quo_calc = {{(DaysWidth - 6){1'b0}}, hour_prod[26:21]};
            DIV_MIN_SEL:  quo_calc = {{(DaysWidth - 7){1'b0}}, min_prod[20:14]};
            default:      quo_calc = '0;
        endcase
    end

    assign quo_times_d = {{(TimeWidth - DaysWidth){1'b0}}, quo_reg}
                       * {{(TimeWidth - DivWidth){1'b0}}, div_const(cmd.div_sel)};

    assign leap       = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
    assign year_len   = leap ? 9'd366 : 9'd365;
    assign mon_len    = month_len(month_reg, leap);
    assign year_fits  = (days_reg < {{(DaysWidth - 9){1'b0}}, year_len});
    assign month_fits = (days_reg < {{(DaysWidth - 5){1'b0}}, mon_len});

    assign status.year_fits  = year_fits;
    assign status.month_done = month_fits || (month_reg == LAST_MONTH);

    always_comb
    begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        days_next   = days_reg;
        year_next   = year_reg;
        mod4_next   = mod4_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        month_next  = month_reg;
        if (cmd.load)
        begin
            rem_next    = sum[TimeWidth] ? '0 : sum[TimeWidth-1:0];
            year_next   = EPOCH_YEAR;
            mod4_next   = EPOCH_MOD4;
            mod100_next = EPOCH_MOD100;
            mod400_next = EPOCH_MOD400;
            month_next  = '0;
        end
        if (cmd.div_quo)
        begin
            quo_next = quo_calc;
        end
        if (cmd.div_rem)
        begin
            rem_next = rem_reg - quo_times_d;
        end
        if (cmd.save_days)
        begin
            days_next = quo_reg;
        end
        if (cmd.year_step && !year_fits)
        begin
            days_next   = days_reg - {{(DaysWidth - 9){1'b0}}, year_len};
            year_next   = year_reg + 12'd1;
            mod4_next   = mod4_reg + 2'd1;
            mod100_next = (mod100_reg == 7'd99) ? 7'd0 : (mod100_reg + 7'd1);
            mod400_next = (mod400_reg == 9'd399) ? 9'd0 : (mod400_reg + 9'd1);
        end
        if (cmd.month_step && !month_fits && (month_reg != LAST_MONTH))
        begin
            days_next  = days_reg - {{(DaysWidth - 5){1'b0}}, mon_len};
            month_next = month_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        days_reg   <= days_next;
        year_reg   <= year_next;
        mod4_reg   <= mod4_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg  <= month_next;
        if (cmd.save_hour)
        begin
            hour_reg <= quo_reg[4:0];
        end
        if (cmd.save_min)
        begin
            minute_reg <= quo_reg[5:0];
        end
    end

    assign year   = year_reg;
    assign month  = month_reg + 4'd1;
    assign day    = days_reg[4:0] + 5'd1;
    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = rem_reg[5:0];

endmodule

@@ rtl/core/epoch_seconds_to_calendar_top.sv @@
// Converts an unsigned count of seconds since 1970-01-01 into Gregorian year, month, day,
// hour, minute and second, after adding the signed time-zone offset (reset 10800 s; a
// negative sum clamps to 1970-01-01 00:00:00). An item is taken when start is high and
// busy is low; done pulses for one cycle with the result, and the receiver cannot stall,
// so capture it then (the fields hold until the next item is taken). The wait for done
// grows with each whole year past 1970 and each month stepped, and busy drops the cycle
// after done: three constant divisions by reciprocal multiplication (a quotient step and
// a remainder step each) split off days, hours and minutes, then the day count is
// stepped down by one year per cycle, then by one month per cycle.
// Write utc_offset_seconds only while busy is low.
module epoch_seconds_to_calendar_top
    import es2c_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   utc_offset_we,
    input  logic [OffsetWidth-1:0] utc_offset_seconds,
    input  logic                   start,
    output logic                   busy,
    input  logic [SecWidth-1:0]    seconds_since_epoch,
    output logic                   done,
    output logic [11:0]            year,
    output logic [3:0]             month,
    output logic [4:0]             day,
    output logic [4:0]             hour,
    output logic [5:0]             minute,
    output logic [5:0]             second
);

    cmd_t    cmd;
    status_t status;

    es2c_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    es2c_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .utc_offset_we       (utc_offset_we),
        .utc_offset_seconds  (utc_offset_seconds),
        .seconds_since_epoch (seconds_since_epoch),
        .cmd                 (cmd),
        .status              (status),
        .year                (year),
        .month               (month),
        .day                 (day),
        .hour                (hour),
        .minute              (minute),
        .second              (second)
    );

endmodule
